// ===== sv/mat_pkg.sv =====
`timescale 1ns / 1ps

package mat_pkg;

  // Buffer and token limits of one address
  localparam int BUF_BYTES  = 512;
  localparam int BUF_SLACK  = 5;
  localparam int MAX_TOKENS = 64;
  localparam int BYTES_W    = 10;
  localparam int TOKENS_W   = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_END_CHAR    = 3'd0,
    REG_OPER_LOW    = 3'd1,
    REG_OPER_HIGH   = 3'd2,
    REG_CLASS_CHAR  = 3'd3,
    REG_REPL_CHAR   = 3'd4,
    REG_NCLASS_CHAR = 3'd5
  } cfg_reg_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_TOO_LONG    = 4'd1,
    ERR_STRAY_PAREN = 4'd2,
    ERR_STRAY_ANGLE = 4'd3,
    ERR_TOO_MANY    = 4'd4,
    ERR_OPEN_PAREN  = 4'd5,
    ERR_OPEN_ANGLE  = 4'd6,
    ERR_OPEN_QUOTE  = 4'd7,
    ERR_EMPTY       = 4'd8
  } err_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
  } res_t;

  // All results caused by one character, at most three
  localparam int BUNDLE_MAX = 3;
  localparam int RES_IDX_W  = 2;

  typedef struct packed {
    logic [RES_IDX_W-1:0] cnt;
    res_t [BUNDLE_MAX-1:0] res;
  } bundle_t;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== sv/mail_address_tokenizer.sv =====
`timescale 1ns / 1ps

// Address tokenizer: push one address character per cycle; each character is
// classified and scanned in the same cycle it is accepted, so input runs at one
// character per clock. A character yields zero to three result words (a token
// byte, a token end, a done or error word), and these leave one word per pop
// from a four-entry queue of per-character bundles, so under a steady stream
// the result side, at one word per cycle, sets the sustained rate; full rises
// only when that queue fills. A byte kept by the scan comes out with the next
// character, so the final words of an address appear on its terminator.
// Configuration writes take effect at once and belong between addresses.

module mail_address_tokenizer import mat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            ch,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind,
  output logic [7:0]            out_byte,
  output logic [3:0]            error_code,
  output logic                  last_of_run
);

  logic    accept;
  logic    bundle_valid;
  bundle_t bundle;
  logic    q_rd;
  logic    q_nonempty;
  bundle_t q_data;

  assign accept = push && !full;

  mat_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .ch           (ch),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  mat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (bundle_valid),
    .wdata    (bundle),
    .full     (full),
    .rd       (q_rd),
    .nonempty (q_nonempty),
    .rdata    (q_data)
  );

  mat_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .out_byte    (out_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

// ===== sv/mat_front.sv =====
`timescale 1ns / 1ps

module mat_front import mat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [7:0]            ch,
  output logic                  bundle_valid,
  output bundle_t               bundle
);

  typedef enum logic [2:0] {
    ST_OPR = 3'd0,
    ST_ATM = 3'd1,
    ST_QST = 3'd2,
    ST_SPC = 3'd3,
    ST_ONE = 3'd4
  } scan_t;

  typedef struct packed {
    scan_t st;
    logic  meta;
    logic  brk;
  } entry_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] DEPTH_MAX = 8'hFF;
  localparam logic [BYTES_W-1:0]  BYTES_LIMIT = BYTES_W'(BUF_BYTES - BUF_SLACK);
  localparam logic [TOKENS_W-1:0] TOKENS_MAX  = TOKENS_W'(MAX_TOKENS);

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_DOLLAR) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LANGLE) || (c == CH_RANGLE) || (c == CH_COMMA) ||
           (c == CH_SEMI) || (c == CH_BSLASH) || (c == CH_QUOTE) ||
           (c == CH_CR) || (c == CH_LF);
  endfunction

  // Break table: state by character class
  function automatic entry_t next_entry(input scan_t st, input scan_t ty);
    entry_t e;
    e = '{st: ST_OPR, meta: 1'b0, brk: 1'b0};
    case (st)
      ST_ATM: begin
        e.st   = ty;
        e.meta = (ty == ST_SPC);
        e.brk  = (ty != ST_ATM);
      end
      ST_QST: begin
        e.st = (ty == ST_QST) ? ST_OPR : ST_QST;
      end
      ST_SPC: begin
        e.st   = ty;
        e.meta = (ty == ST_SPC);
      end
      ST_ONE: begin
        e.st = ST_OPR;
      end
      default: begin
        e.st   = ty;
        e.meta = (ty == ST_SPC);
        e.brk  = 1'b1;
      end
    endcase
    return e;
  endfunction

  // Configuration registers
  logic [7:0]  end_char;
  logic [63:0] oper_set_low;
  logic [63:0] oper_set_high;
  logic [7:0]  class_char;
  logic [7:0]  repl_char;
  logic [7:0]  nclass_char;

  // Scan state
  scan_t               scan_state, scan_state_next;
  logic [7:0]          held_byte, held_byte_next;
  logic                held_valid, held_valid_next;
  logic                escape_pending, escape_pending_next;
  logic [7:0]          comment_depth, comment_depth_next;
  logic [7:0]          angle_depth, angle_depth_next;
  logic [BYTES_W-1:0]  bytes_used, bytes_used_next;
  logic [TOKENS_W-1:0] token_count, token_count_next;
  logic                token_open, token_open_next;

  function automatic scan_t char_type(input logic [7:0] c, input logic [7:0] cc,
                                      input logic [7:0] rc, input logic [7:0] nc,
                                      input logic [127:0] opers);
    scan_t t;
    if (c == cc || c == rc || c == nc) begin
      t = ST_ONE;
    end else if (c == CH_QUOTE) begin
      t = ST_QST;
    end else if (c[7]) begin
      t = ST_ATM;
    end else if (is_space(c) || c == CH_RPAREN) begin
      t = ST_SPC;
    end else if (c < CH_SPACE || c == CH_DEL || is_delim(c) || opers[c[6:0]]) begin
      t = ST_OPR;
    end else begin
      t = ST_ATM;
    end
    return t;
  endfunction

  logic [7:0]           c;
  logic                 keep;
  logic                 abort;
  logic                 do_finish;
  logic                 do_close;
  logic                 clear_all;
  logic [RES_IDX_W-1:0] n;
  scan_t                ty;
  entry_t               ent;
  bundle_t              b;

  // Work out every result and the next state for this character
  always_comb begin
    scan_state_next     = scan_state;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    escape_pending_next = escape_pending;
    comment_depth_next  = comment_depth;
    angle_depth_next    = angle_depth;
    bytes_used_next     = bytes_used;
    token_count_next    = token_count;
    token_open_next     = token_open;
    b         = '0;
    n         = '0;
    keep      = 1'b1;
    abort     = 1'b0;
    do_finish = 1'b0;
    do_close  = 1'b0;
    clear_all = 1'b0;
    c         = {1'b0, ch[6:0]};
    ty        = ST_OPR;
    ent       = '{st: ST_OPR, meta: 1'b0, brk: 1'b0};

    // Emit the byte held from the previous character
    if (held_valid) begin
      if (bytes_used >= BYTES_LIMIT) begin
        b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_TOO_LONG};
        n = n + 1'b1;
        abort     = 1'b1;
        clear_all = 1'b1;
      end else begin
        b.res[n] = '{kind: KIND_BYTE, data: held_byte, err: ERR_NONE};
        n = n + 1'b1;
        bytes_used_next = bytes_used_next + 1'b1;
        token_open_next = 1'b1;
        held_valid_next = 1'b0;
      end
    end

    if (!abort) begin
      if (ch == 8'd0) begin
        do_finish = 1'b1;
      end else begin
        // Escapes, comments and brackets
        if (escape_pending) begin
          c[7] = 1'b1;
          escape_pending_next = 1'b0;
        end else if (c == CH_BSLASH) begin
          escape_pending_next = 1'b1;
          keep = 1'b0;
        end else if (scan_state == ST_QST) begin
          keep = 1'b1;
        end else if (c == CH_LPAREN) begin
          if (comment_depth != DEPTH_MAX) begin
            comment_depth_next = comment_depth + 1'b1;
          end
          keep = 1'b0;
        end else if (c == CH_RPAREN) begin
          if (comment_depth == 8'd0) begin
            b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_STRAY_PAREN};
            n = n + 1'b1;
            abort     = 1'b1;
            clear_all = 1'b1;
          end else begin
            comment_depth_next = comment_depth - 1'b1;
          end
        end else if (comment_depth != 8'd0) begin
          keep = 1'b0;
        end else if (c == CH_LANGLE) begin
          if (angle_depth != DEPTH_MAX) begin
            angle_depth_next = angle_depth + 1'b1;
          end
        end else if (c == CH_RANGLE) begin
          if (angle_depth == 8'd0) begin
            b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_STRAY_ANGLE};
            n = n + 1'b1;
            abort     = 1'b1;
            clear_all = 1'b1;
          end else begin
            angle_depth_next = angle_depth - 1'b1;
          end
        end else if (end_char == CH_SPACE && is_space(c)) begin
          c = CH_SPACE;
        end

        // Delimiter check, then the break table
        if (keep && !abort) begin
          if (end_char != 8'd0 && c == end_char && angle_depth_next == 8'd0 &&
              scan_state != ST_QST) begin
            do_finish = 1'b1;
          end else begin
            ty  = char_type(c, class_char, repl_char, nclass_char,
                            {oper_set_high, oper_set_low});
            ent = next_entry(scan_state, ty);
            scan_state_next = ent.st;
            if (!ent.meta) begin
              held_byte_next  = c;
              held_valid_next = 1'b1;
            end
            do_close = ent.brk;
          end
        end
      end
    end

    // Close the open token
    if ((do_finish || do_close) && token_open_next) begin
      if (token_count >= TOKENS_MAX) begin
        b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_TOO_MANY};
        n = n + 1'b1;
        abort     = 1'b1;
        clear_all = 1'b1;
      end else begin
        b.res[n] = '{kind: KIND_END, data: 8'd0, err: ERR_NONE};
        n = n + 1'b1;
        bytes_used_next  = bytes_used_next + 1'b1;
        token_count_next = token_count + 1'b1;
        token_open_next  = 1'b0;
      end
    end

    // Final checks at the end of the address
    if (do_finish && !abort) begin
      clear_all = 1'b1;
      if (comment_depth_next != 8'd0) begin
        b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_OPEN_PAREN};
      end else if (angle_depth_next != 8'd0) begin
        b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_OPEN_ANGLE};
      end else if (scan_state_next == ST_QST) begin
        b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_OPEN_QUOTE};
      end else if (token_count_next == '0) begin
        b.res[n] = '{kind: KIND_ERR, data: 8'd0, err: ERR_EMPTY};
      end else begin
        b.res[n] = '{kind: KIND_DONE, data: 8'd0, err: ERR_NONE};
      end
      n = n + 1'b1;
    end

    // Drop the session after a final result
    if (clear_all) begin
      scan_state_next     = ST_OPR;
      held_byte_next      = 8'd0;
      held_valid_next     = 1'b0;
      escape_pending_next = 1'b0;
      comment_depth_next  = 8'd0;
      angle_depth_next    = 8'd0;
      bytes_used_next     = '0;
      token_count_next    = '0;
      token_open_next     = 1'b0;
    end

    b.cnt = n;
  end

  assign bundle       = b;
  assign bundle_valid = accept && (n != '0);

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      end_char      <= 8'd0;
      oper_set_low  <= 64'd0;
      oper_set_high <= 64'd0;
      class_char    <= 8'd0;
      repl_char     <= 8'd0;
      nclass_char   <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_END_CHAR:    end_char      <= cfg_data[7:0];
        REG_OPER_LOW:    oper_set_low  <= cfg_data;
        REG_OPER_HIGH:   oper_set_high <= cfg_data;
        REG_CLASS_CHAR:  class_char    <= cfg_data[7:0];
        REG_REPL_CHAR:   repl_char     <= cfg_data[7:0];
        REG_NCLASS_CHAR: nclass_char   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance the scan state on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_OPR;
      held_byte      <= 8'd0;
      held_valid     <= 1'b0;
      escape_pending <= 1'b0;
      comment_depth  <= 8'd0;
      angle_depth    <= 8'd0;
      bytes_used     <= '0;
      token_count    <= '0;
      token_open     <= 1'b0;
    end else if (accept) begin
      scan_state     <= scan_state_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      escape_pending <= escape_pending_next;
      comment_depth  <= comment_depth_next;
      angle_depth    <= angle_depth_next;
      bytes_used     <= bytes_used_next;
      token_count    <= token_count_next;
      token_open     <= token_open_next;
    end
  end

endmodule

// ===== sv/mat_queue.sv =====
`timescale 1ns / 1ps

module mat_queue import mat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wdata,
  output logic    full,
  input  logic    rd,
  output logic    nonempty,
  output bundle_t rdata
);

  bundle_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                do_wr;
  logic                do_rd;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign rdata    = slots[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;

  // Store incoming bundles
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/mat_back.sv =====
`timescale 1ns / 1ps

module mat_back import mat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  bundle_t    q_data,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [3:0] error_code,
  output logic       last_of_run
);

  bundle_t              cur;
  logic                 cur_valid;
  logic [RES_IDX_W-1:0] idx;
  logic                 is_last;
  logic                 taken;
  res_t                 r;

  assign r        = cur.res[idx];
  assign is_last  = (idx == cur.cnt - 1'b1);
  assign taken    = pop && cur_valid;
  assign q_rd     = q_nonempty && (!cur_valid || (taken && is_last));

  assign empty       = !cur_valid;
  assign kind        = r.kind;
  assign out_byte    = r.data;
  assign error_code  = r.err;
  assign last_of_run = is_last;

  // Hold the current bundle
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  // Step through the bundle one word per pop
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (taken) begin
      if (is_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

// ===== sv/mat_checker.sv =====
`timescale 1ns / 1ps

module mat_checker import mat_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic [3:0] error_code,
  input logic       last_of_run
);

  // Nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // A done or error word closes the run of its character
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_DONE || kind == KIND_ERR)) |-> last_of_run)
    else $error("final word not last of run");

  // Only token bytes carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_BYTE) |-> (out_byte == 8'd0))
    else $error("byte on non-byte word");

  // An error code appears exactly on error words
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((kind == KIND_ERR) == (error_code != ERR_NONE)))
    else $error("error code mismatch");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(out_byte) &&
                          $stable(error_code) && $stable(last_of_run)))
    else $error("stalled word changed");

endmodule

bind mail_address_tokenizer mat_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .kind        (kind),
  .out_byte    (out_byte),
  .error_code  (error_code),
  .last_of_run (last_of_run)
);

// ===== tb/mail_address_tokenizer_tb.sv =====
`timescale 1ns / 1ps

module mail_address_tokenizer_tb;
  import mat_pkg::*;

  // Scan states, also used as character classes
  typedef enum logic [2:0] {
    SC_OPR = 3'd0,
    SC_ATM = 3'd1,
    SC_QST = 3'd2,
    SC_SPC = 3'd3,
    SC_ONE = 3'd4
  } scan_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
    logic       last;
  } word_t;

  localparam int PERIOD         = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL     = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_CHARS   = 45;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  push      = 1'b0;
  logic                  full;
  logic [7:0]            ch        = 8'h00;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            out_byte;
  logic [3:0]            error_code;
  logic                  last_of_run;

  mail_address_tokenizer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .ch          (ch),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .out_byte    (out_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

  // Tokenizer copy: configuration
  logic [7:0]          end_chr, class_chr, repl_chr, nclass_chr;
  logic [63:0]         oper_lo, oper_hi;
  // Tokenizer copy: scan state of the current address
  scan_t               scan_st;
  logic [7:0]          held_byte, cmt_depth, ang_depth;
  logic                held_ok, esc_pend, tok_open;
  logic [BYTES_W-1:0]  bytes_used;
  logic [TOKENS_W-1:0] tok_cnt;

  word_t      exp_words[$];
  word_t      step_words[$];
  logic [7:0] char_q[$];

  int mismatches    = 0;
  int words_checked = 0;
  int chars_in      = 0;
  int addr_done     = 0;
  int addr_err      = 0;
  int stim_count    = 0;
  int stuck_cycles  = 0;
  int send_gap      = 0;
  int take_gap      = 0;
  int stall_left    = 0;
  int stall_req     = 0;
  int stall_seen    = 0;
  bit calm          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_address();
    scan_st    = SC_OPR;
    held_byte  = '0;
    held_ok    = 1'b0;
    esc_pend   = 1'b0;
    cmt_depth  = '0;
    ang_depth  = '0;
    bytes_used = '0;
    tok_cnt    = '0;
    tok_open   = 1'b0;
  endtask

  task automatic add_word(kind_t k, logic [7:0] d, err_t e);
    word_t w;
    w.kind = k;
    w.data = d;
    w.err  = e;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic abort_address(err_t e);
    add_word(KIND_ERR, 8'h00, e);
    clear_address();
  endtask

  function automatic bit is_white(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    case (c)
      "$", "(", ")", "<", ">", ",", ";", CH_BSLASH, CH_QUOTE, CH_CR, CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic scan_t char_class(logic [7:0] c);
    if (c == class_chr || c == repl_chr || c == nclass_chr) return SC_ONE;
    if (c == CH_QUOTE) return SC_QST;
    if (c[7]) return SC_ATM;
    if (is_white(c) || c == CH_RPAREN) return SC_SPC;
    if (c < 8'd32 || c == CH_DEL || is_delim(c)) return SC_OPR;
    if (c < 8'd64 ? oper_lo[c[5:0]] : oper_hi[c[5:0]]) return SC_OPR;
    return SC_ATM;
  endfunction

  // Break table: next state, whether the char is dropped, whether a token closes
  task automatic scan_next(scan_t st, scan_t cls, output scan_t nxt, output bit meta,
                           output bit brk);
    nxt  = cls;
    meta = (cls == SC_SPC);
    brk  = 1'b0;
    case (st)
      SC_OPR: brk = 1'b1;
      SC_ATM: brk = (cls != SC_ATM);
      SC_QST: begin
        nxt  = (cls == SC_QST) ? SC_OPR : SC_QST;
        meta = 1'b0;
      end
      SC_ONE: begin
        nxt  = SC_OPR;
        meta = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic close_token(output bit failed);
    failed = 1'b0;
    if (tok_open) begin
      if (tok_cnt >= MAX_TOKENS) begin
        abort_address(ERR_TOO_MANY);
        failed = 1'b1;
      end else begin
        add_word(KIND_END, 8'h00, ERR_NONE);
        bytes_used++;
        tok_cnt++;
        tok_open = 1'b0;
      end
    end
  endtask

  task automatic end_address();
    bit failed;
    close_token(failed);
    if (!failed) begin
      if (cmt_depth != 0) abort_address(ERR_OPEN_PAREN);
      else if (ang_depth != 0) abort_address(ERR_OPEN_ANGLE);
      else if (scan_st == SC_QST) abort_address(ERR_OPEN_QUOTE);
      else if (tok_cnt == 0) abort_address(ERR_EMPTY);
      else begin
        add_word(KIND_DONE, 8'h00, ERR_NONE);
        clear_address();
      end
    end
  endtask

  // Work out the words one accepted character causes and queue them
  task automatic tokenize_char(logic [7:0] in_ch);
    logic [7:0] c;
    bit keep, stop, failed, meta, brk;
    scan_t nxt;
    word_t w;
    step_words.delete();
    stop = 1'b0;
    keep = 1'b1;
    // flush the byte held from the previous character
    if (held_ok) begin
      if (bytes_used >= BUF_BYTES - BUF_SLACK) begin
        abort_address(ERR_TOO_LONG);
        stop = 1'b1;
      end else begin
        add_word(KIND_BYTE, held_byte, ERR_NONE);
        bytes_used++;
        tok_open = 1'b1;
        held_ok  = 1'b0;
      end
    end
    if (!stop && in_ch == CH_NUL) begin
      end_address();
      stop = 1'b1;
    end
    if (!stop) begin
      c = {1'b0, in_ch[6:0]};
      if (esc_pend) begin
        c[7]     = 1'b1;
        esc_pend = 1'b0;
      end else if (c == CH_BSLASH) begin
        esc_pend = 1'b1;
        keep     = 1'b0;
      end else if (scan_st == SC_QST) begin
        // quoted text passes as is
      end else if (c == CH_LPAREN) begin
        if (cmt_depth != 8'hFF) cmt_depth++;
        keep = 1'b0;
      end else if (c == CH_RPAREN) begin
        if (cmt_depth == 0) begin
          abort_address(ERR_STRAY_PAREN);
          stop = 1'b1;
        end else cmt_depth--;
      end else if (cmt_depth != 0) begin
        keep = 1'b0;
      end else if (c == CH_LANGLE) begin
        if (ang_depth != 8'hFF) ang_depth++;
      end else if (c == CH_RANGLE) begin
        if (ang_depth == 0) begin
          abort_address(ERR_STRAY_ANGLE);
          stop = 1'b1;
        end else ang_depth--;
      end else if (end_chr == CH_SPACE && is_white(c)) begin
        c = CH_SPACE;
      end
      if (!stop && keep) begin
        if (end_chr != 0 && c == end_chr && ang_depth == 0 && scan_st != SC_QST) begin
          end_address();
        end else begin
          scan_next(scan_st, char_class(c), nxt, meta, brk);
          scan_st = nxt;
          if (!meta) begin
            held_byte = c;
            held_ok   = 1'b1;
          end
          if (brk) close_token(failed);
        end
      end
    end
    // mark the last word of this character
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
    foreach (step_words[i]) exp_words.push_back(step_words[i]);
  endtask

  task automatic set_register(cfg_reg_t idx, logic [63:0] val);
    case (idx)
      REG_END_CHAR:    end_chr    = val[7:0];
      REG_OPER_LOW:    oper_lo    = val;
      REG_OPER_HIGH:   oper_hi    = val;
      REG_CLASS_CHAR:  class_chr  = val[7:0];
      REG_REPL_CHAR:   repl_chr   = val[7:0];
      REG_NCLASS_CHAR: nclass_chr = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_word();
    word_t want;
    if (exp_words.size() == 0) begin
      report_mismatch("word with none pending, kind", 32'(kind), 0);
    end else begin
      want = exp_words.pop_front();
      if (kind != want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
      if (out_byte != want.data)
        report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
      if (error_code != want.err)
        report_mismatch("error_code", 32'(error_code), 32'(want.err));
      if (last_of_run != want.last)
        report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
      if (want.kind == KIND_DONE) addr_done++;
      else if (want.kind == KIND_ERR) addr_err++;
      words_checked++;
    end
  endtask

  // Sample both handshakes and the register port; watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      end_chr    = '0;
      oper_lo    = '0;
      oper_hi    = '0;
      class_chr  = '0;
      repl_chr   = '0;
      nclass_chr = '0;
      clear_address();
      exp_words.delete();
    end else begin
      if (cfg_write) set_register(cfg_reg_t'(cfg_index), cfg_data);
      if (pop && !empty) check_word();
      if (push && !full) begin
        tokenize_char(ch);
        void'(char_q.pop_front());
        chars_in++;
      end
      if ((pop && !empty) || (push && !full)) begin
        stuck_cycles = 0;
      end else if (char_q.size() > 0 || exp_words.size() > 0) begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no word moved for %0d cycles", stuck_cycles);
          $display("Mismatches found");
          $finish;
        end
      end else begin
        stuck_cycles = 0;
      end
    end
  end

  // Offer the oldest pending character, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (send_gap == 0 && !calm && $urandom_range(0, 15) == 0)
        send_gap = $urandom_range(1, 12);
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (char_q.size() > 0) begin
        push <= 1'b1;
        ch   <= char_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Take result words, with random gaps and one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        if (take_gap == 0 && !calm && $urandom_range(0, 15) == 0)
          take_gap = $urandom_range(1, 12);
        if (take_gap > 0) begin
          take_gap--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic program_regs(logic [7:0] e, logic [63:0] lo, logic [63:0] hi,
                              logic [7:0] cl, logic [7:0] rp, logic [7:0] nc);
    write_reg(REG_END_CHAR, {56'd0, e});
    write_reg(REG_OPER_LOW, lo);
    write_reg(REG_OPER_HIGH, hi);
    write_reg(REG_CLASS_CHAR, {56'd0, cl});
    write_reg(REG_REPL_CHAR, {56'd0, rp});
    write_reg(REG_NCLASS_CHAR, {56'd0, nc});
    cfg_write <= 1'b0;
  endtask

  // Hold until every character is in and every word is out, then let the block settle
  task automatic drain();
    while (char_q.size() > 0 || exp_words.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] c);
    char_q.push_back(c);
    stim_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) c = 8'("0" + $urandom_range(0, 9));
    else c = 8'("a" + $urandom_range(0, 25));
    c[7] = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_QUOTE) c = "q";
    return c;
  endfunction

  task automatic send_atom();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_char(atom_char());
  endtask

  // One random piece of an address: mostly well-formed, some noise
  task automatic send_piece();
    int n;
    string ops;
    ops = "@.,;:$";
    case ($urandom_range(0, 9))
      0, 1: send_atom();
      2: begin
        send_char(CH_QUOTE);
        n = $urandom_range(0, 4);
        repeat (n) send_char(text_char());
        send_char(CH_QUOTE);
      end
      3: begin
        send_char(CH_LPAREN);
        send_atom();
        if ($urandom_range(0, 3) == 0) send_text("(x)");
        send_char(CH_RPAREN);
      end
      4: begin
        send_char(CH_LANGLE);
        send_atom();
        send_text("@");
        send_atom();
        send_char(CH_RANGLE);
      end
      5: send_char(ops[$urandom_range(0, ops.len() - 1)]);
      6: begin
        n = $urandom_range(8, 13);
        send_char(n == 8 ? CH_SPACE : 8'(n));
      end
      7: begin
        send_char(CH_BSLASH);
        send_char(8'($urandom_range(1, 255)));
      end
      8: begin
        if ($urandom_range(0, 1)) send_char(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: send_char(class_chr == 0 ? 8'h80 : class_chr);
          1: send_char(repl_chr == 0 ? 8'h80 : repl_chr);
          default: send_char(nclass_chr == 0 ? 8'h80 : nclass_chr);
        endcase
      end
      default: send_char(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic send_address();
    int parts;
    parts = $urandom_range(1, 6);
    repeat (parts) send_piece();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_char(CH_NUL);
      6, 7: send_char(end_chr == 0 ? CH_NUL : end_chr);
      8: send_char($urandom_range(0, 1) ? CH_RPAREN : CH_RANGLE);
      default: ;
    endcase
  endtask

  task automatic send_random_run();
    int target;
    target = stim_count + RANDOM_CHARS;
    while (stim_count < target) send_address();
    send_char(CH_NUL);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults everywhere: basic scan, most errors, the token limit
    program_regs(8'h00, 64'd0, 64'd0, 8'h00, 8'h00, 8'h00);
    send_char(CH_NUL);
    send_text("a@b.c");        send_char(CH_NUL);
    send_text("\"q x\"");      send_char(CH_NUL);
    send_text("\"open");       send_char(CH_NUL);
    send_text("(c(d))x");      send_char(CH_NUL);
    send_text("(x");           send_char(CH_NUL);
    send_text(")");
    send_text("<a>");          send_char(CH_NUL);
    send_text("<a");           send_char(CH_NUL);
    send_text(">");
    send_text("a\\");          send_char(CH_NUL);
    send_text("\\(a");         send_char(CH_NUL);
    send_char(8'h80); send_char("A"); send_char(CH_NUL);
    send_char(8'hFF); send_char("b"); send_char(CH_NUL);
    // token limit
    repeat (33) send_text("a,");
    send_char(CH_NUL);
    drain();

    // Comma delimiter, random operator maps; hold the receiver off to fill the block
    program_regs(",", {$urandom, $urandom}, {$urandom, $urandom}, "=", "$", "^");
    send_text("<a,b>,c"); send_char(CH_NUL);
    send_random_run();
    stall_req++;
    drain();

    // Space delimiter, every operator bit set, metacharacters at the extremes
    program_regs(CH_SPACE, '1, '1, 8'hFF, 8'h80, 8'h00);
    send_text("<a b> c\td");   send_char(CH_NUL);
    send_random_run();
    drain();

    // Delimiter reachable only as an escaped DEL
    program_regs(8'hFF, 64'd0, 64'd0, 8'($urandom), 8'($urandom), 8'($urandom));
    send_text("ab"); send_char(CH_BSLASH); send_char(CH_DEL); send_text("cd");
    send_char(CH_NUL);
    send_random_run();
    drain();

    // Fully random settings, no idling on either side
    calm = 1'b1;
    program_regs(8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                 8'($urandom), 8'($urandom), 8'($urandom));
    send_random_run();
    drain();

    if (exp_words.size() != 0) report_mismatch("words never delivered", 0, exp_words.size());
    $display("Covered %0d characters and %0d result words over five register settings",
             chars_in, words_checked);
    $display("Addresses ended: %0d done, %0d in error", addr_done, addr_err);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
